@@ rtl/core/oast_pkg.sv @@
// package: shared types, constants and hash helpers for the symbol table
`default_nettype none
package oast_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned KeyBytes   = 8;
  localparam int unsigned SlotW      = $clog2(TableDepth);
  localparam int unsigned SizeW      = 7;
  localparam int unsigned KeyW       = 8 * KeyBytes;
  localparam int unsigned LenW       = 4;
  localparam int unsigned ValW       = 32;
  localparam int unsigned CntW       = 6;
  localparam int unsigned EntryW     = KeyW + LenW + ValW;
  localparam logic [SizeW-1:0] SizeReset = 7'd51;

  typedef enum logic [1:0] {
    CmdInstall  = 2'd0,
    CmdAssign   = 2'd1,
    CmdRetrieve = 2'd2,
    CmdNone     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    BeIdle, BeHome, BeRead, BeCheck, BeStep, BeOut
  } be_state_e;

  // classified request passed from front to back
  typedef struct packed {
    cmd_e                    cmd;
    logic [KeyW-1:0]         key;
    logic [LenW-1:0]         len;
    logic [ValW-1:0]         value;
    logic [7:0]              hash;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic [SlotW-1:0]        slot;
    logic [ValW-1:0]         value_out;
    logic [CntW-1:0]         probe_count;
  } rsp_t;

  function automatic logic [KeyW-1:0] key_mask(input logic [LenW-1:0] len);
    logic [KeyW-1:0] m;
    m = '0;
    for (int i = 0; i < KeyBytes; i++) begin
      if (32'(i) < 32'(len)) m[8*i +: 8] = 8'hff;
    end
    return m;
  endfunction

  // raw 8-bit hash before the size reduction
  function automatic logic [7:0] raw_hash(input logic [KeyW-1:0] key,
                                          input logic [LenW-1:0] len);
    logic [11:0] h;
    h = 12'(key[3:0]) + 12'(key[15:8]) * 12'd15 + 12'(len) * 12'd16;
    return h[7:0];
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/oast_if.sv @@
// interfaces: item channels with valid/ready handshake
`default_nettype none
interface oast_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic [oast_pkg::KeyW-1:0]    key;
  logic [oast_pkg::LenW-1:0]    key_length;
  logic signed [oast_pkg::ValW-1:0] value;
  modport source (output valid, command, key, key_length, value, input ready);
  modport sink   (input valid, command, key, key_length, value, output ready);
endinterface

interface oast_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [oast_pkg::SlotW-1:0]   slot;
  logic signed [oast_pkg::ValW-1:0] value_out;
  logic [oast_pkg::CntW-1:0]    probe_count;
  modport source (output valid, status, slot, value_out, probe_count, input ready);
  modport sink   (input valid, status, slot, value_out, probe_count, output ready);
endinterface

interface oast_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [oast_pkg::SizeW-1:0]    data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/open_addressing_symbol_table_top.sv @@
// open addressing symbol table: top level with config register and checks
//
// usage: req carries command, key, key_length and value; rsp returns
// status, slot, value_out and probe_count, one item per request.
// the user must write table_size over cfg (7 bits, reset 51) only while
// the block is idle; the block itself does not enforce it. values below
// 2 act as 2 and above 64 as 64. a two-entry queue decouples request
// intake from the probe sequencer, so up to two requests are accepted
// while one is in progress. an item waits in the queue, is started by
// the sequencer, has its home hash reduced by repeated subtraction of
// size, then is probed, each probe reading and checking a slot and then
// reducing the increment, with at most size/2+1 probes; the output
// register is loaded last. an unused command skips the probes.
// items are handled one at a time, so the probe loop sets the throughput.
// reset clears the occupancy bits at once, so the table is empty and
// the first request may enter on the first cycle after reset.
// when rsp is stalled the result waits in the output register, the
// sequencer holds in its output state and the queue keeps filling.
// cfg.ready is always high.
`default_nettype none
module open_addressing_symbol_table_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  oast_req_if.sink    req,
  oast_rsp_if.source  rsp,
  oast_cfg_if.sink    cfg
);
  logic [oast_pkg::SizeW-1:0] size_q;
  logic                       q_valid, q_pop, busy;
  oast_pkg::req_t             q_head;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= oast_pkg::SizeReset;
    else if (cfg.valid) size_q <= cfg.data;
  end

  oast_front u_front (
    .clk_i, .rst_ni, .req, .q_valid_o(q_valid), .q_pop_i(q_pop), .q_head_o(q_head)
  );

  oast_back u_back (
    .clk_i, .rst_ni, .size_raw_i(size_q), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_head_i(q_head), .rsp, .busy_o(busy)
  );

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_rsp_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> rsp.status != 2'd3) else $error("bad status");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> busy) else $error("result pending while idle");
endmodule
`default_nettype wire

@@ rtl/core/oast_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module oast_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ rtl/core/oast_front.sv @@
// front end: masks the name, computes the raw hash, two-entry request queue
`default_nettype none
module oast_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  oast_req_if.sink           req,
  output logic               q_valid_o,
  input  wire logic          q_pop_i,
  output oast_pkg::req_t     q_head_o
);
  oast_pkg::req_t        ent_q [2];
  logic                  rd_q, wr_q;
  logic [1:0]            cnt_q;
  oast_pkg::req_t        in_r;
  logic [oast_pkg::LenW-1:0] len_c;
  logic [oast_pkg::KeyW-1:0] key_c;
  logic                  push;

  always_comb begin
    len_c = (req.key_length > oast_pkg::LenW'(oast_pkg::KeyBytes)) ?
            oast_pkg::LenW'(oast_pkg::KeyBytes) : req.key_length;
    key_c = req.key & oast_pkg::key_mask(len_c);
    in_r.cmd   = oast_pkg::cmd_e'(req.command);
    in_r.key   = key_c;
    in_r.len   = len_c;
    in_r.value = req.value;
    in_r.hash  = oast_pkg::raw_hash(key_c, len_c);
  end

  assign req.ready = (cnt_q != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_head_o  = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= in_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/oast_back.sv @@
// back end: probe sequencer over the slot memory, output register
`default_nettype none
module oast_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [oast_pkg::SizeW-1:0] size_raw_i,
  input  wire logic                      q_valid_i,
  output logic                           q_pop_o,
  input  wire oast_pkg::req_t            q_head_i,
  oast_rsp_if.source                     rsp,
  output logic                           busy_o
);
  localparam int unsigned SW = oast_pkg::SlotW;
  localparam int unsigned DW = oast_pkg::TableDepth;
  localparam int unsigned CW1 = oast_pkg::CntW - 1;

  oast_pkg::be_state_e state_q, state_d;
  oast_pkg::req_t      cur_q, cur_d;
  logic [7:0]          h_q, h_d;     // home reduction, then slot
  logic [SW:0]         incr_q, incr_d;
  logic [12:0]         sq_q, sq_d;
  logic [CW1:0]        cnt_q, cnt_d;
  logic [DW-1:0]       used_q;
  logic                set_used;
  logic [SW:0]         size_c;
  logic [SW-1:0]       limit_c;
  oast_pkg::rsp_t      res_q, res_d;  // result being built
  oast_pkg::rsp_t      out_q, out_d;
  logic                ov_q, ov_d;
  logic                we;
  logic [oast_pkg::EntryW-1:0] wdata, rdata;
  logic [SW-1:0]       addr;
  logic [8:0]          hsum;
  logic [12:0]         sqr;

  always_comb begin
    if (size_raw_i < 7'd2) size_c = (SW+1)'(2);
    else if (size_raw_i > 7'(DW)) size_c = (SW+1)'(DW);
    else size_c = (SW+1)'(size_raw_i);
    limit_c = SW'(size_c >> 1);
  end

  assign addr = h_q[SW-1:0];
  oast_ram #(.Width(oast_pkg::EntryW), .Depth(DW)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign rsp.valid       = ov_q;
  assign rsp.status      = out_q.status;
  assign rsp.slot        = out_q.slot;
  assign rsp.value_out   = out_q.value_out;
  assign rsp.probe_count = out_q.probe_count;
  assign busy_o          = (state_q != oast_pkg::BeIdle) || q_valid_i || ov_q;

  always_comb begin
    logic [oast_pkg::KeyW-1:0] rkey;
    logic [oast_pkg::LenW-1:0] rlen;
    logic [oast_pkg::ValW-1:0] rval;
    state_d = state_q; cur_d = cur_q; h_d = h_q; incr_d = incr_q;
    sq_d = sq_q; cnt_d = cnt_q; res_d = res_q; out_d = out_q; ov_d = ov_q;
    q_pop_o = 1'b0; we = 1'b0; set_used = 1'b0;
    wdata = {cur_q.key, cur_q.len, cur_q.value};
    {rkey, rlen, rval} = rdata;
    hsum = 9'(h_q) + 9'(incr_q);
    sqr = 13'(incr_q) + 13'd1;
    sqr = sqr * sqr;
    if (ov_q && rsp.ready) ov_d = 1'b0;
    unique case (state_q)
      oast_pkg::BeIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d = q_head_i;
          h_d = (q_head_i.len < 4'd2) ? 8'd0 : q_head_i.hash;
          incr_d = (size_c == (SW+1)'(1)) ? '0 : (SW+1)'(1);
          cnt_d = '0;
          res_d = '{oast_pkg::StNotFound, '0, '0, '0};
          state_d = (q_head_i.cmd == oast_pkg::CmdNone) ? oast_pkg::BeOut :
                    oast_pkg::BeHome;
        end
      end
      // reduce home hash modulo size by repeated subtraction
      oast_pkg::BeHome: begin
        if (9'(h_q) >= 9'(size_c)) h_d = h_q - 8'(size_c);
        else state_d = oast_pkg::BeRead;
      end
      oast_pkg::BeRead: state_d = oast_pkg::BeCheck;
      oast_pkg::BeCheck: begin
        if (!used_q[addr]) begin
          if (cur_q.cmd == oast_pkg::CmdInstall) begin
            we = 1'b1; set_used = 1'b1;
            res_d = '{oast_pkg::StOk, addr, '0, cnt_q};
          end
          state_d = oast_pkg::BeOut;
        end else if (rkey == cur_q.key && rlen == cur_q.len) begin
          res_d.status = oast_pkg::StOk;
          res_d.slot = addr;
          if (cur_q.cmd == oast_pkg::CmdInstall) res_d.probe_count = cnt_q;
          else if (cur_q.cmd == oast_pkg::CmdAssign) we = 1'b1;
          else res_d.value_out = rval;
          state_d = oast_pkg::BeOut;
        end else begin
          h_d = (hsum >= 9'(size_c)) ? 8'(hsum - 9'(size_c)) : 8'(hsum);
          sq_d = sqr;
          cnt_d = cnt_q + 1'b1;
          if (32'(cnt_q) + 1 > 32'(limit_c)) begin
            if (cur_q.cmd == oast_pkg::CmdInstall) res_d.status = oast_pkg::StFull;
            state_d = oast_pkg::BeOut;
          end else state_d = oast_pkg::BeStep;
        end
      end
      // incr = (incr+1)^2 mod size, one subtraction a cycle
      oast_pkg::BeStep: begin
        if (sq_q >= 13'(size_c) * 13'd32) sq_d = sq_q - 13'(size_c) * 13'd32;
        else if (sq_q >= 13'(size_c)) sq_d = sq_q - 13'(size_c);
        else begin
          incr_d = (SW+1)'(sq_q);
          state_d = oast_pkg::BeRead;
        end
      end
      oast_pkg::BeOut: begin
        if (!ov_q || rsp.ready) begin
          out_d = res_q;
          ov_d = 1'b1;
          state_d = oast_pkg::BeIdle;
        end
      end
      default: state_d = oast_pkg::BeIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; h_q <= h_d; incr_q <= incr_d; sq_q <= sq_d;
    cnt_q <= cnt_d; res_q <= res_d; out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oast_pkg::BeIdle;
      ov_q <= 1'b0;
      used_q <= '0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
      if (set_used) used_q[addr] <= 1'b1;
    end
  end
endmodule
`default_nettype wire
